// ----- hdl/wrrp_pkg.sv -----
// Shared constants for the weighted round robin picker.
// No dependencies; used by the top level and its checker.
package wrrp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_WEIGHTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_STATUS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_CHANCE = 2'd2;

    localparam logic [1:0] STATUS_READY = 2'd1;
    localparam logic [1:0] STATUS_PROBE = 2'd3;

    // 0.05 of full scale, rounded
    localparam logic [15:0] PROBE_CHANCE_RST = 16'd3277;

    localparam logic ERR_NONE    = 1'b0;
    localparam logic ERR_NO_NODE = 1'b1;

endpackage

// ----- hdl/weighted_round_robin_picker.sv -----
// Weighted round robin node picker: top level and its sequencer.
// Depends on wrrp_pkg.
//
// One request is handled at a time; s_ready is high only while the sequencer
// is idle, and a finished result waits in the output register without
// blocking the next request. A request after a configuration write first
// rebuilds the list: each node index in turn is considered for insertion,
// then a subtractive gcd unit runs over every listed weight. A probe pick
// then runs through the bit-serial remainder unit; a rotation pick first
// reduces the cursor and then inspects list entries one at a time, a number
// that grows with the number of weight levels passed.
module weighted_round_robin_picker
    import wrrp_pkg::*;
#(
    parameter int NODES       = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_has_excluded,
    input  logic [2:0]            s_excluded_node,
    input  logic [15:0]           s_random_roll,
    input  logic [7:0]            s_random_pick,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_chosen_node,
    output logic                  m_chosen_by_probe,
    output logic                  m_error_code
);

    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int LVL_W = 9;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BUILD, ST_GINIT, ST_GLOAD, ST_GRUN,
        ST_DECIDE, ST_PMOD, ST_PSEL, ST_CMOD, ST_SCAN, ST_OUT
    } state_t;

    state_t state_reg;

    logic [CFG_DATA_W-1:0]  weights_reg;
    logic [15:0]            status_reg;
    logic [15:0]            chance_reg;
    logic                   refresh_reg;

    logic [IDX_W-1:0]       order_reg [NODES];
    logic [WEIGHT_BITS-1:0] wts_reg   [NODES];
    logic [CNT_W-1:0]       count_reg;
    logic [WEIGHT_BITS-1:0] top_reg;
    logic [WEIGHT_BITS-1:0] gcd_reg;
    logic [IDX_W-1:0]       cursor_reg;
    logic [LVL_W-1:0]       level_reg;
    logic [NODES-1:0]       probe_reg;

    logic [IDX_W-1:0]       idx_reg;
    logic [WEIGHT_BITS-1:0] ga_reg, gb_reg;
    logic [3:0]             rem_reg;
    logic [2:0]             bit_reg;

    logic                   excl_en_reg;
    logic [2:0]             excl_reg;
    logic [15:0]            roll_reg;
    logic [7:0]             pick_reg;

    logic [2:0]             res_node_reg;
    logic                   res_probe_reg;
    logic                   res_err_reg;

    // node weight and status of the node under insertion
    logic [WEIGHT_BITS-1:0] new_w;
    logic [1:0]             new_s;
    logic [CNT_W-1:0]       ins_pos;

    always_comb begin
        new_w   = weights_reg[{3'(idx_reg), 3'd0} +: WEIGHT_BITS];
        new_s   = status_reg[{3'(idx_reg), 1'b0} +: 2];
        ins_pos = '0;
        for (int j = 0; j < NODES; j++) begin
            if (CNT_W'(j) < count_reg && wts_reg[j] >= new_w) begin
                ins_pos = ins_pos + 1'b1;
            end
        end
    end

    // probe set size and the selected member
    logic [CNT_W-1:0] probe_cnt;
    logic [IDX_W-1:0] probe_sel;
    logic [3:0]       rem_shift;

    always_comb begin
        logic [CNT_W-1:0] seen;
        probe_cnt = '0;
        probe_sel = '0;
        seen      = '0;
        for (int i = 0; i < NODES; i++) begin
            if (probe_reg[i]) begin
                if (4'(seen) == rem_reg) begin
                    probe_sel = IDX_W'(i);
                end
                seen = seen + 1'b1;
            end
        end
        probe_cnt = seen;
        rem_shift = {rem_reg[2:0], pick_reg[bit_reg]};
    end

    // rotation candidate
    logic [WEIGHT_BITS-1:0] cur_w;
    logic [IDX_W-1:0]       cur_node;
    logic                   cur_last;
    logic [LVL_W-1:0]       level_step;

    always_comb begin
        cur_w      = wts_reg[cursor_reg];
        cur_node   = order_reg[cursor_reg];
        cur_last   = (CNT_W'(cursor_reg) + 1'b1) == count_reg;
        level_step = (level_reg >= LVL_W'(top_reg)) ? '0 : (level_reg + LVL_W'(gcd_reg));
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            weights_reg <= '0;
            status_reg  <= '0;
            chance_reg  <= PROBE_CHANCE_RST;
            refresh_reg <= 1'b1;
            count_reg   <= '0;
            top_reg     <= '0;
            gcd_reg     <= '0;
            cursor_reg  <= '0;
            level_reg   <= '0;
            probe_reg   <= '0;
            m_valid     <= 1'b0;
        end else begin
            // ST_OUT reloads the output register itself
            if (m_valid && m_ready && state_reg != ST_OUT) begin
                m_valid <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NODE_WEIGHTS: begin
                        weights_reg <= cfg_wr_data;
                        refresh_reg <= 1'b1;
                    end
                    REG_NODE_STATUS: begin
                        status_reg  <= cfg_wr_data[15:0];
                        refresh_reg <= 1'b1;
                    end
                    REG_PROBE_CHANCE: begin
                        chance_reg  <= cfg_wr_data[15:0];
                        refresh_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        excl_en_reg <= s_has_excluded;
                        excl_reg    <= s_excluded_node;
                        roll_reg    <= s_random_roll;
                        pick_reg    <= s_random_pick;
                        if (refresh_reg) begin
                            idx_reg   <= '0;
                            count_reg <= '0;
                            probe_reg <= '0;
                            state_reg <= ST_BUILD;
                        end else begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_BUILD: begin
                    if (new_w != '0 && new_s == STATUS_READY) begin
                        for (int j = 0; j < NODES; j++) begin
                            if (CNT_W'(j) == ins_pos) begin
                                order_reg[j] <= idx_reg;
                                wts_reg[j]   <= new_w;
                            end
                        end
                        for (int j = 1; j < NODES; j++) begin
                            if (CNT_W'(j) > ins_pos) begin
                                order_reg[j] <= order_reg[j-1];
                                wts_reg[j]   <= wts_reg[j-1];
                            end
                        end
                        count_reg <= count_reg + 1'b1;
                    end else if (new_w != '0 && new_s == STATUS_PROBE) begin
                        probe_reg[idx_reg] <= 1'b1;
                    end
                    if (IDX_W'(NODES - 1) == idx_reg) begin
                        refresh_reg <= 1'b0;
                        state_reg   <= ST_GINIT;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_GINIT: begin
                    gcd_reg <= '0;
                    idx_reg <= '0;
                    top_reg <= (count_reg == '0) ? '0 : wts_reg[0];
                    state_reg <= (count_reg == '0) ? ST_DECIDE : ST_GLOAD;
                end
                ST_GLOAD: begin
                    ga_reg    <= wts_reg[idx_reg];
                    gb_reg    <= gcd_reg;
                    state_reg <= ST_GRUN;
                end
                ST_GRUN: begin
                    // subtractive Euclid: one subtract or swap per cycle
                    if (gb_reg == '0) begin
                        gcd_reg <= ga_reg;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= ((CNT_W'(idx_reg) + 1'b1) == count_reg) ?
                                     ST_DECIDE : ST_GLOAD;
                    end else if (ga_reg >= gb_reg) begin
                        ga_reg <= ga_reg - gb_reg;
                    end else begin
                        ga_reg <= gb_reg;
                        gb_reg <= ga_reg;
                    end
                end
                ST_DECIDE: begin
                    res_node_reg  <= '0;
                    res_probe_reg <= 1'b0;
                    res_err_reg   <= ERR_NONE;
                    if (!excl_en_reg && probe_reg != '0 && roll_reg <= chance_reg) begin
                        rem_reg   <= '0;
                        bit_reg   <= 3'd7;
                        state_reg <= ST_PMOD;
                    end else if (count_reg == '0) begin
                        res_err_reg <= ERR_NO_NODE;
                        state_reg   <= ST_OUT;
                    end else if (count_reg == CNT_W'(1)) begin
                        res_node_reg <= 3'(order_reg[0]);
                        state_reg    <= ST_OUT;
                    end else begin
                        state_reg <= ST_CMOD;
                    end
                end
                ST_PMOD: begin
                    // restoring remainder, one pick bit per cycle
                    rem_reg <= (rem_shift >= 4'(probe_cnt)) ?
                               rem_shift - 4'(probe_cnt) : rem_shift;
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 3'd0) begin
                        state_reg <= ST_PSEL;
                    end
                end
                ST_PSEL: begin
                    probe_reg[probe_sel] <= 1'b0;
                    res_node_reg  <= 3'(probe_sel);
                    res_probe_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_CMOD: begin
                    if (CNT_W'(cursor_reg) >= count_reg) begin
                        cursor_reg <= cursor_reg - IDX_W'(count_reg);
                    end else begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (LVL_W'(cur_w) > level_reg) begin
                        cursor_reg <= cur_last ? '0 : cursor_reg + 1'b1;
                        if (cur_last) begin
                            level_reg <= level_step;
                        end
                        if (!(excl_en_reg && 3'(cur_node) == excl_reg)) begin
                            res_node_reg <= 3'(cur_node);
                            state_reg    <= ST_OUT;
                        end
                    end else begin
                        level_reg  <= level_step;
                        cursor_reg <= '0;
                    end
                end
                ST_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid           <= 1'b1;
                        m_chosen_node     <= res_node_reg;
                        m_chosen_by_probe <= res_probe_reg;
                        m_error_code      <= res_err_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/wrrp_checker.sv -----
// Port-level checker for the weighted round robin picker, bound to the top.
// Depends on wrrp_pkg.
module wrrp_checker
    import wrrp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_chosen_node,
    input logic       m_chosen_by_probe,
    input logic       m_error_code
);

    // an error result names no node and no probe
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code == ERR_NO_NODE |-> m_chosen_node == 3'd0 && !m_chosen_by_probe)
        else $error("error result carries a node");

    // one request at a time: busy right after a transfer in
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting a request");

    // a result never appears in the cycle right after acceptance
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_node)
            && $stable(m_chosen_by_probe) && $stable(m_error_code))
        else $error("stalled result changed");

endmodule

bind weighted_round_robin_picker wrrp_checker u_wrrp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_chosen_node     (m_chosen_node),
    .m_chosen_by_probe (m_chosen_by_probe),
    .m_error_code      (m_error_code)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for weighted_round_robin_picker.
// Depends on wrrp_pkg and the picker RTL; it predicts each pick and checks
// the result stream under random idle gaps on both sides.
`timescale 1ns / 100ps

module testbench;
    import wrrp_pkg::*;

    localparam int NODES       = 8;
    localparam int WEIGHT_BITS = 8;
    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [2:0] node;
        logic       probe;
        logic       err;
    } pick_t;

    typedef struct packed {
        logic        excl_en;
        logic [2:0]  excl;
        logic [15:0] roll;
        logic [7:0]  pick;
    } request_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_has_excluded;
    logic [2:0]            s_excluded_node;
    logic [15:0]           s_random_roll;
    logic [7:0]            s_random_pick;
    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_chosen_node;
    logic                  m_chosen_by_probe;
    logic                  m_error_code;

    weighted_round_robin_picker #(
        .NODES(NODES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) dut (.*);

    // picker model state
    logic [63:0] wgt_reg;
    logic [15:0] status_reg;
    logic [15:0] chance_reg;
    logic        list_stale;
    logic [2:0]  order [8];
    int          order_len;
    int          top_wgt;
    int          wgt_gcd;
    int          scan_pos;
    int          level;
    logic [7:0]  probe_set;

    request_t pending_reqs[$];
    pick_t    expected_picks[$];
    int       sent_cnt;
    int       accepted_cnt;
    int       checked_cnt;
    int       probe_cnt;
    int       error_cnt;
    int       fail_cnt;
    int       cycle_cnt;
    int       gap_left;
    int       stall_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int node_wgt(input int n);
        return int'((wgt_reg >> (n * 8)) & ((64'd1 << WEIGHT_BITS) - 1));
    endfunction

    function automatic logic [1:0] node_status(input int n);
        return status_reg[n*2 +: 2];
    endfunction

    function automatic int gcd(input int a, input int b);
        int t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic void rebuild_list();
        int j;
        probe_set = '0;
        order_len = 0;
        for (int i = 0; i < NODES; i++) begin
            if (node_wgt(i) == 0) continue;
            if (node_status(i) == STATUS_READY) begin
                j = order_len;
                // ties keep index order: stop at the first heavier-or-equal entry
                while (j > 0 && node_wgt(order[j-1]) < node_wgt(i)) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = 3'(i);
                order_len++;
            end else if (node_status(i) == STATUS_PROBE) begin
                probe_set[i] = 1'b1;
            end
        end
        top_wgt = (order_len > 0) ? node_wgt(order[0]) : 0;
        wgt_gcd = 0;
        for (int i = 0; i < order_len; i++) wgt_gcd = gcd(node_wgt(order[i]), wgt_gcd);
    endfunction

    function automatic void advance_level();
        level = (level >= top_wgt) ? 0 : ((level + wgt_gcd) & 9'h1FF);
    endfunction

    function automatic pick_t predict_pick(input request_t req);
        pick_t res;
        int    cnt;
        int    k;
        int    sel;
        int    node;
        res = '0;
        res.err = ERR_NONE;
        if (list_stale) begin
            rebuild_list();
            list_stale = 1'b0;
        end
        if (!req.excl_en && probe_set != 0 && req.roll <= chance_reg) begin
            cnt = $countones(probe_set);
            k = req.pick % cnt;
            sel = 0;
            for (int i = 0; i < 8; i++) begin
                if (probe_set[i]) begin
                    if (k == 0) begin
                        sel = i;
                        break;
                    end
                    k--;
                end
            end
            probe_set[sel] = 1'b0;
            res.node = 3'(sel);
            res.probe = 1'b1;
            return res;
        end
        if (order_len == 0) begin
            res.err = ERR_NO_NODE;
            return res;
        end
        if (order_len == 1) begin
            res.node = order[0];
            return res;
        end
        scan_pos = scan_pos % order_len;
        forever begin
            node = order[scan_pos];
            if (node_wgt(node) > level) begin
                scan_pos = (scan_pos + 1) % order_len;
                if (scan_pos == 0) advance_level();
                if (req.excl_en && node == req.excl) continue;
                res.node = 3'(node);
                return res;
            end
            advance_level();
            scan_pos = 0;
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && accepted_cnt != sent_cnt) begin
            // still waiting for the transfer
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (pending_reqs.size() > 0) begin
            request_t req;
            req = pending_reqs.pop_front();
            s_has_excluded  <= req.excl_en;
            s_excluded_node <= req.excl;
            s_random_roll   <= req.roll;
            s_random_pick   <= req.pick;
            s_valid         <= 1'b1;
            sent_cnt++;
            gap_left = idle_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall_left = idle_len();
        end
    end

    // request capture, prediction and result check
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("FAILURE");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            request_t req;
            req = {s_has_excluded, s_excluded_node, s_random_roll, s_random_pick};
            expected_picks.insert(expected_picks.size(), predict_pick(req));
            accepted_cnt++;
        end
        if (aresetn && m_valid && m_ready) begin
            pick_t got;
            pick_t want;
            got = {m_chosen_node, m_chosen_by_probe, m_error_code};
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected result node=%0d probe=%0b err=%0b",
                         $time, got.node, got.probe, got.err);
                fail_cnt++;
            end else begin
                want = expected_picks.pop_front();
                if (got.node !== want.node) begin
                    $display("%0t: chosen_node exp %0d got %0d", $time, want.node, got.node);
                    fail_cnt++;
                end
                if (got.probe !== want.probe) begin
                    $display("%0t: chosen_by_probe exp %0b got %0b",
                             $time, want.probe, got.probe);
                    fail_cnt++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: error_code exp %0b got %0b", $time, want.err, got.err);
                    fail_cnt++;
                end
                checked_cnt++;
                if (want.probe) probe_cnt++;
                if (want.err == ERR_NO_NODE) error_cnt++;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_NODE_WEIGHTS: begin wgt_reg = val; list_stale = 1'b1; end
            REG_NODE_STATUS:  begin status_reg = val[15:0]; list_stale = 1'b1; end
            REG_PROBE_CHANCE: begin chance_reg = val[15:0]; list_stale = 1'b1; end
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_picks.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic add_req(input logic e, input logic [2:0] x, input logic [15:0] r,
                           input logic [7:0] p);
        pending_reqs.insert(pending_reqs.size(), {e, x, r, p});
    endtask

    function automatic logic [63:0] rand_weights();
        logic [63:0] w;
        int r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)      w[i*8 +: 8] = 8'd0;
            else if (r < 80) w[i*8 +: 8] = 8'($urandom_range(1, 12));
            else if (r < 90) w[i*8 +: 8] = 8'(2 * $urandom_range(1, 6));
            else if (r < 95) w[i*8 +: 8] = 8'd255;
            else             w[i*8 +: 8] = 8'($urandom_range(1, 255));
        end
        return w;
    endfunction

    function automatic logic [15:0] rand_status();
        logic [15:0] s;
        int r;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 9);
            if (r < 5)      s[i*2 +: 2] = STATUS_READY;
            else if (r < 8) s[i*2 +: 2] = STATUS_PROBE;
            else            s[i*2 +: 2] = 2'($urandom_range(0, 1) ? 0 : 2);
        end
        return s;
    endfunction

    initial begin
        logic [15:0] roll;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_has_excluded = 1'b0;
        s_excluded_node = '0;
        s_random_roll = '0;
        s_random_pick = '0;
        m_ready = 1'b0;
        wgt_reg = '0;
        status_reg = '0;
        chance_reg = PROBE_CHANCE_RST;
        list_stale = 1'b1;
        order_len = 0;
        top_wgt = 0;
        wgt_gcd = 0;
        scan_pos = 0;
        level = 0;
        probe_set = '0;
        sent_cnt = 0;
        accepted_cnt = 0;
        checked_cnt = 0;
        probe_cnt = 0;
        error_cnt = 0;
        fail_cnt = 0;
        cycle_cnt = 0;
        gap_left = 0;
        stall_left = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // out of reset nothing is listed: errors
        add_req(1'b0, 3'd0, 16'd0, 8'd0);
        add_req(1'b1, 3'd7, 16'hFFFF, 8'hFF);
        drain();

        // ties, a zero-weight ready node, probes, an excluded status
        write_reg(REG_NODE_WEIGHTS, 64'h00_05_FF_03_05_01_00_FF);
        write_reg(REG_NODE_STATUS, 64'({STATUS_PROBE, STATUS_READY, STATUS_PROBE, 2'd2,
                                        STATUS_READY, STATUS_READY, STATUS_READY,
                                        STATUS_READY}));
        write_reg(REG_PROBE_CHANCE, 64'hFFFF);
        add_req(1'b0, 3'd0, 16'hFFFF, 8'hFF);   // probe, pick wraps
        add_req(1'b1, 3'd0, 16'd0, 8'd0);       // exclusion blocks probing
        add_req(1'b0, 3'd0, 16'd0, 8'd0);       // probe set now empty: rotation pick
        for (int i = 0; i < 8; i++) add_req(1'b1, 3'(i), 16'hFFFF, 8'h55);
        add_req(1'b0, 3'd5, 16'hAAAA, 8'hAA);
        drain();

        // unmapped index changes nothing; chance zero refuses roll one
        write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PROBE_CHANCE, 64'd0);
        add_req(1'b0, 3'd0, 16'd1, 8'd1);
        drain();

        // single ready node, returned even when excluded
        write_reg(REG_NODE_WEIGHTS, 64'h00_00_00_00_00_80_00_00);
        write_reg(REG_NODE_STATUS, 64'({14'd0, STATUS_READY} << 4));
        add_req(1'b1, 3'd2, 16'h1234, 8'd3);
        add_req(1'b0, 3'd2, 16'd0, 8'd3);
        drain();

        for (int ph = 0; ph < 30; ph++) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_NODE_WEIGHTS, rand_weights());
                1: write_reg(REG_NODE_STATUS, 64'(rand_status()));
                default: begin
                    write_reg(REG_NODE_WEIGHTS, rand_weights());
                    write_reg(REG_NODE_STATUS, 64'(rand_status()));
                end
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(REG_PROBE_CHANCE, 64'd0);
                1: write_reg(REG_PROBE_CHANCE, 64'hFFFF);
                2: write_reg(REG_PROBE_CHANCE, 64'(PROBE_CHANCE_RST));
                3: write_reg(REG_PROBE_CHANCE, 64'($urandom_range(0, 65535)));
                default: ;
            endcase
            for (int i = 0; i < 31; i++) begin
                roll = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 4000))
                                              : 16'($urandom_range(0, 65535));
                add_req(($urandom_range(0, 99) < 40), 3'($urandom_range(0, 7)), roll,
                        8'($urandom_range(0, 255)));
            end
            drain();
        end

        $display("Checked %0d picks over %0d requests: %0d from probe set, %0d no-node errors.",
                 checked_cnt, sent_cnt, probe_cnt, error_cnt);
        $display("Config phases varied weights, node status and probe chance incl. extremes.");
        if (fail_cnt == 0 && expected_picks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
